>>> rtl/nyq_pkg.sv
// Shared types and constants for the NCC YIQ texel decoder.
package nyq_pkg;

   localparam int TEXEL_W    = 16;
   localparam int INDEX_W    = 4;
   localparam int LANE_W     = 2;
   localparam int VALUE_W    = 9;
   localparam int LUMA_W     = 8;
   localparam int ROW_W      = 2;
   localparam int LUMA_DEPTH = 16;
   localparam int CHROMA_ROWS = 4;
   localparam int CHANNELS   = 3;
   localparam int SUM_W      = 11;
   localparam int ARGB_W     = 32;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
   localparam logic [7:0] CHAN_MAX     = 8'hFF;

   typedef enum logic [1:0] {
      KIND_DECODE = 2'd0,
      KIND_LUMA   = 2'd1,
      KIND_I      = 2'd2,
      KIND_Q      = 2'd3
   } kind_type;

   typedef logic [CHANNELS-1:0][VALUE_W-1:0] lane_set_type;

   // Table access request from the pipeline to the memories
   typedef struct packed {
      logic               rd_en;
      logic [INDEX_W-1:0] luma_addr;
      logic [ROW_W-1:0]   i_addr;
      logic [ROW_W-1:0]   q_addr;
      logic               wr_luma;
      logic               wr_i;
      logic               wr_q;
      logic [INDEX_W-1:0] wr_addr;
      logic [LANE_W-1:0]  wr_lane;
      logic [VALUE_W-1:0] wr_value;
   } tbl_ctl_type;

   // Registered read data from the memories
   typedef struct packed {
      logic [LUMA_W-1:0] luma;
      lane_set_type      i_lanes;
      lane_set_type      q_lanes;
   } tbl_data_type;

endpackage

>>> rtl/nyq_if.sv
// Valid/ready channel interfaces for texel requests and pixel responses.
interface nyq_req_if;
   logic                            valid;
   logic                            ready;
   nyq_pkg::kind_type               kind;
   logic [nyq_pkg::TEXEL_W-1:0]     texel;
   logic                            last_texel;
   logic [nyq_pkg::INDEX_W-1:0]     entry_index;
   logic [nyq_pkg::LANE_W-1:0]      channel;
   logic signed [nyq_pkg::VALUE_W-1:0] entry_value;

   modport source (output valid, kind, texel, last_texel, entry_index, channel,
                   entry_value, input ready);
   modport sink (input valid, kind, texel, last_texel, entry_index, channel,
                 entry_value, output ready);
endinterface

interface nyq_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [nyq_pkg::ARGB_W-1:0]   argb;
   logic                         last_pixel;

   modport source (output valid, argb, last_pixel, input ready);
   modport sink (input valid, argb, last_pixel, output ready);
endinterface

>>> rtl/ncc_yiq_texel_decoder_core.sv
// Top level: NCC YIQ texel decoder with table loading and ARGB output.
// A decode result passes through the table read registers and then the output register.
// Throughput: one item per cycle unless the response channel stalls; the table memories read once per decode.
// Table writes return no response.
// Reset clears the pipeline valid flags and mode_ff; the table
// contents are undefined until written.
module ncc_yiq_texel_decoder_core (
   input  logic          clock,
   input  logic          reset,
   nyq_req_if.sink       req,
   nyq_rsp_if.source     rsp,
   input  logic          csr_write_enable,
   input  logic          csr_write_data
);

   logic mode_ff, mode_in;
   logic s1_valid_ff, s1_valid_in;
   logic out_valid_ff, out_valid_in;
   logic [7:0] s1_alpha_ff;
   logic       s1_last_ff;
   logic [nyq_pkg::ARGB_W-1:0] argb_ff, argb_in;
   logic       last_ff;

   logic out_free;
   logic accept;
   logic is_decode;
   logic chroma_ok;

   nyq_pkg::tbl_ctl_type  tbl_ctl;
   nyq_pkg::tbl_data_type tbl_data;

   // Handshake
   assign out_free  = !out_valid_ff || rsp.ready;
   assign req.ready = !s1_valid_ff || out_free;
   assign accept    = req.valid && req.ready;
   assign is_decode = req.kind == nyq_pkg::KIND_DECODE;
   assign chroma_ok = req.entry_index < nyq_pkg::INDEX_W'(nyq_pkg::CHROMA_ROWS)
                      && req.channel < nyq_pkg::LANE_W'(nyq_pkg::CHANNELS);

   // Build the table request
   always_comb begin
      tbl_ctl.rd_en     = accept && is_decode;
      tbl_ctl.luma_addr = req.texel[7:4];
      tbl_ctl.i_addr    = req.texel[3:2];
      tbl_ctl.q_addr    = req.texel[1:0];
      tbl_ctl.wr_luma   = accept && req.kind == nyq_pkg::KIND_LUMA;
      tbl_ctl.wr_i      = accept && req.kind == nyq_pkg::KIND_I && chroma_ok;
      tbl_ctl.wr_q      = accept && req.kind == nyq_pkg::KIND_Q && chroma_ok;
      tbl_ctl.wr_addr   = req.entry_index;
      tbl_ctl.wr_lane   = req.channel;
      tbl_ctl.wr_value  = req.entry_value;
   end

   nyq_tables u_tables (
      .clock (clock),
      .ctl   (tbl_ctl),
      .data  (tbl_data)
   );

   // Sum luma, I and Q per channel, clamp to 0..255, and add alpha
   always_comb begin
      logic signed [nyq_pkg::SUM_W-1:0] sum;
      argb_in = '0;
      for (int c = 0; c < nyq_pkg::CHANNELS; c++) begin
         sum = $signed({3'b000, tbl_data.luma})
               + nyq_pkg::SUM_W'($signed(tbl_data.i_lanes[c]))
               + nyq_pkg::SUM_W'($signed(tbl_data.q_lanes[c]));
         if (sum[nyq_pkg::SUM_W-1]) begin
            argb_in[8*c +: 8] = 8'h00;
         end else if (sum[nyq_pkg::SUM_W-2:8] != '0) begin
            argb_in[8*c +: 8] = nyq_pkg::CHAN_MAX;
         end else begin
            argb_in[8*c +: 8] = sum[7:0];
         end
      end
      argb_in[31:24] = mode_ff ? s1_alpha_ff : nyq_pkg::ALPHA_OPAQUE;
   end

   // Next control state
   always_comb begin
      mode_in = csr_write_enable ? csr_write_data : mode_ff;

      if (accept) begin
         s1_valid_in = is_decode;
      end else if (out_free) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (s1_valid_ff && out_free) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture sideband on decode transfer, advance result into output register
   always_ff @(posedge clock) begin
      if (accept && is_decode) begin
         s1_alpha_ff <= req.texel[15:8];
         s1_last_ff  <= req.last_texel;
      end
      if (s1_valid_ff && out_free) begin
         argb_ff <= argb_in;
         last_ff <= s1_last_ff;
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.argb       = argb_ff;
   assign rsp.last_pixel = last_ff;

endmodule

>>> rtl/nyq_tables.sv
// Luma and chroma table memories with one-cycle registered reads.
module nyq_tables (
   input  logic                 clock,
   input  nyq_pkg::tbl_ctl_type ctl,
   output nyq_pkg::tbl_data_type data
);

   typedef struct packed {
      nyq_pkg::lane_set_type q;
      nyq_pkg::lane_set_type i;
   } chroma_row_type;

   logic [nyq_pkg::LUMA_W-1:0] luma_mem [nyq_pkg::LUMA_DEPTH];
   chroma_row_type             chroma_mem [nyq_pkg::CHROMA_ROWS];

   logic [nyq_pkg::LUMA_W-1:0] luma_rd_ff;
   nyq_pkg::lane_set_type      i_rd_ff;
   nyq_pkg::lane_set_type      q_rd_ff;

   // Write luma by entry, chroma by row and channel lane
   always_ff @(posedge clock) begin
      if (ctl.wr_luma) begin
         luma_mem[ctl.wr_addr] <= ctl.wr_value[nyq_pkg::LUMA_W-1:0];
      end
      for (int c = 0; c < nyq_pkg::CHANNELS; c++) begin
         if (ctl.wr_i && ctl.wr_lane == nyq_pkg::LANE_W'(c)) begin
            chroma_mem[ctl.wr_addr[nyq_pkg::ROW_W-1:0]].i[c] <= ctl.wr_value;
         end
         if (ctl.wr_q && ctl.wr_lane == nyq_pkg::LANE_W'(c)) begin
            chroma_mem[ctl.wr_addr[nyq_pkg::ROW_W-1:0]].q[c] <= ctl.wr_value;
         end
      end
   end

   // Read on decode transfers only; hold the data while the pipeline stalls
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         luma_rd_ff <= luma_mem[ctl.luma_addr];
         i_rd_ff    <= chroma_mem[ctl.i_addr].i;
         q_rd_ff    <= chroma_mem[ctl.q_addr].q;
      end
   end

   assign data.luma    = luma_rd_ff;
   assign data.i_lanes = i_rd_ff;
   assign data.q_lanes = q_rd_ff;

endmodule
